// ===== hw/rtl/gocl_pkg.sv =====
// ----------------------------------------------------------------------------
// gocl_pkg: shared types and constants for greedy graph coloring
// Widths of ids, colors and counts, the queue entry type and the
// free-color priority encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gocl_pkg;

  localparam int ID_W            = 8;
  localparam int COLOR_W         = 8;
  localparam int NUM_COLORS      = 256;
  localparam int TOTAL_W         = 9;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);

  // input stream packing
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int USER_NBV   = 0;
  localparam int USER_FRESH = 1;

  // output stream packing, padded to whole bytes
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - ID_W - COLOR_W - TOTAL_W;

  // one classified item between front and back
  typedef struct packed {
    logic [ID_W-1:0] vertex;
    logic [ID_W-1:0] neighbor;
    logic            nb_hit;   // real neighbor inside the table
    logic            v_store;  // vertex id inside the table
    logic            last;
    logic            fresh;
  } gocl_entry_t;

  // smallest clear bit of the used mask, saturates at the top color
  function automatic logic [COLOR_W-1:0] first_free(input logic [NUM_COLORS-1:0] used);
    logic [NUM_COLORS-1:0] free;
    logic [NUM_COLORS-1:0] low;
    logic [COLOR_W-1:0]    code;
    free = ~used;
    low  = free & (~free + NUM_COLORS'(1));
    code = '0;
    for (int k = 0; k < COLOR_W; k++) begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        if (((i >> k) & 1) == 1) begin
          code[k] = code[k] | low[i];
        end
      end
    end
    if (free == '0) begin
      code = COLOR_W'(NUM_COLORS - 1);
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/greedy_ordered_graph_coloring.sv =====
// A vertex's last item passes through the item queue and the stage register before its result is registered.
// Throughput: one input item per cycle, held by the result register only
// while a finished result waits on m_axis_tready.
// The item queue holds 4 classified items between front and back.
// Reset clears queue, stage, marks, mask and total; the color table is not
// cleared, entries are read only behind their colored mark.
// ----------------------------------------------------------------------------
// greedy_ordered_graph_coloring: greedy graph coloring top level
// Vertices arrive in coloring order with one neighbor per transfer; each
// vertex gets the smallest color not held by a colored neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_ordered_graph_coloring #(
  parameter int MAX_VERTICES = gocl_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] vertex, [15:8] neighbor
  input  wire logic [gocl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // last_of_vertex
  input  wire logic                              s_axis_tlast,
  // [0] neighbor_valid, [1] new_graph
  input  wire logic [gocl_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] colored_vertex, [15:8] assigned_color, [24:16] colors_in_use, rest zero
  output logic [gocl_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import gocl_pkg::*;

  logic               q_valid, q_ready;
  gocl_entry_t        q_entry;
  logic [ID_W-1:0]    colored_vertex;
  logic [COLOR_W-1:0] assigned_color;
  logic [TOTAL_W-1:0] colors_in_use;

  // accept and classify
  gocl_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .vertex_i         (s_axis_tdata[ID_W-1:0]),
    .neighbor_i       (s_axis_tdata[2*ID_W-1:ID_W]),
    .neighbor_valid_i (s_axis_tuser[USER_NBV]),
    .last_i           (s_axis_tlast),
    .fresh_i          (s_axis_tuser[USER_FRESH]),
    .q_valid_o        (q_valid),
    .q_ready_i        (q_ready),
    .q_entry_o        (q_entry)
  );

  // lookup, mask and color assignment
  gocl_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_ready_o        (q_ready),
    .q_entry_i        (q_entry),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .colored_vertex_o (colored_vertex),
    .assigned_color_o (assigned_color),
    .colors_in_use_o  (colors_in_use)
  );

  // result packing
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, colors_in_use, assigned_color, colored_vertex};

endmodule

`default_nettype wire

// ===== hw/rtl/gocl_front.sv =====
// ----------------------------------------------------------------------------
// gocl_front: input acceptance, classification and item queue
// Flags neighbor and vertex ids that fall inside the table and buffers
// classified items so the back end can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module gocl_front #(
  parameter int MAX_VERTICES = gocl_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [gocl_pkg::ID_W-1:0]  vertex_i,
  input  wire logic [gocl_pkg::ID_W-1:0]  neighbor_i,
  input  wire logic                       neighbor_valid_i,
  input  wire logic                       last_i,
  input  wire logic                       fresh_i,
  output logic                            q_valid_o,
  input  wire logic                       q_ready_i,
  output gocl_pkg::gocl_entry_t           q_entry_o
);
  import gocl_pkg::*;

  gocl_entry_t           entry;
  gocl_entry_t           buf_q [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]       count_q, count_d;
  logic                  push, pop;

  // classify the incoming item
  always_comb begin
    entry.vertex   = vertex_i;
    entry.neighbor = neighbor_i;
    entry.nb_hit   = neighbor_valid_i && (32'(neighbor_i) < MAX_VERTICES);
    entry.v_store  = 32'(vertex_i) < MAX_VERTICES;
    entry.last     = last_i;
    entry.fresh    = fresh_i;
  end

  // queue handshake
  assign in_ready_o = count_q != (QPTR_W+1)'(QDEPTH);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = count_q != '0;
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = buf_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gocl_back.sv =====
// ----------------------------------------------------------------------------
// gocl_back: color lookup, used-color mask and color assignment
// Reads the stored neighbor color, marks it used, and on the last item
// of a vertex picks the smallest free color and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gocl_back #(
  parameter int MAX_VERTICES = gocl_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  output logic                               q_ready_o,
  input  wire gocl_pkg::gocl_entry_t         q_entry_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [gocl_pkg::ID_W-1:0]          colored_vertex_o,
  output logic [gocl_pkg::COLOR_W-1:0]       assigned_color_o,
  output logic [gocl_pkg::TOTAL_W-1:0]       colors_in_use_o
);
  import gocl_pkg::*;

  localparam int DEPTH = (MAX_VERTICES < (1 << ID_W)) ? MAX_VERTICES : (1 << ID_W);
  localparam int IDX_W = $clog2(DEPTH);

  logic [COLOR_W-1:0]    table_mem [DEPTH];
  logic [DEPTH-1:0]      marks_q, marks_d;
  logic [NUM_COLORS-1:0] mask_q;
  logic [TOTAL_W-1:0]    total_q;

  gocl_entry_t           s2_q;
  logic                  s2_valid_q;
  logic                  s2_colored_q;
  logic [COLOR_W-1:0]    rd_q;
  logic                  byp_q;
  logic [COLOR_W-1:0]    byp_color_q;

  logic                  out_valid_q;
  logic [ID_W-1:0]       out_vertex_q;
  logic [COLOR_W-1:0]    out_color_q;
  logic [TOTAL_W-1:0]    out_total_q;

  logic                  s2_fire, pop;
  logic                  wr_en, wr_hit, clr_fire, colored_d;
  logic [IDX_W-1:0]      rd_idx, wr_idx;
  logic [COLOR_W-1:0]    nb_color, new_color;
  logic [NUM_COLORS-1:0] mask_base, mask_with;
  logic [TOTAL_W-1:0]    total_base, color_plus, total_new;

  // stage control
  assign s2_fire   = s2_valid_q && (!s2_q.last || !out_valid_q || out_ready_i);
  assign pop       = q_valid_i && (!s2_valid_q || s2_fire);
  assign q_ready_o = !s2_valid_q || s2_fire;

  assign rd_idx   = q_entry_i.neighbor[IDX_W-1:0];
  assign wr_idx   = s2_q.vertex[IDX_W-1:0];
  assign wr_en    = s2_fire && s2_q.last && s2_q.v_store;
  assign clr_fire = s2_fire && s2_q.fresh;
  assign wr_hit   = wr_en && (wr_idx == rd_idx);

  // neighbor colored as seen after this edge's clear and write
  assign colored_d = q_entry_i.nb_hit && !q_entry_i.fresh &&
                     (wr_hit || (!clr_fire && marks_q[rd_idx]));

  // marks after this edge's clear and write
  always_comb begin
    marks_d = clr_fire ? '0 : marks_q;
    if (wr_en) begin
      marks_d[wr_idx] = 1'b1;
    end
  end

  // mask update and free color pick
  always_comb begin
    nb_color   = byp_q ? byp_color_q : rd_q;
    mask_base  = s2_q.fresh ? '0 : mask_q;
    mask_with  = mask_base;
    if (s2_colored_q) begin
      mask_with = mask_base | (NUM_COLORS'(1) << nb_color);
    end
    new_color  = first_free(mask_with);
    total_base = s2_q.fresh ? '0 : total_q;
    color_plus = {1'b0, new_color} + TOTAL_W'(1);
    total_new  = (color_plus > total_base) ? color_plus : total_base;
  end

  // color table, read on pop, written when a vertex is colored
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_idx] <= new_color;
    end
    if (pop) begin
      rd_q <= table_mem[rd_idx];
    end
  end

  // stage payload and write bypass
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_q         <= q_entry_i;
      s2_colored_q <= colored_d;
      byp_q        <= wr_hit;
      byp_color_q  <= new_color;
    end
  end

  // stage valid, marks, mask and running total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      marks_q    <= '0;
      mask_q     <= '0;
      total_q    <= '0;
    end else begin
      if (pop) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      marks_q <= marks_d;
      if (s2_fire) begin
        mask_q  <= s2_q.last ? '0 : mask_with;
        total_q <= s2_q.last ? total_new : total_base;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire && s2_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_q.last) begin
      out_vertex_q <= s2_q.vertex;
      out_color_q  <= new_color;
      out_total_q  <= total_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign colored_vertex_o = out_vertex_q;
  assign assigned_color_o = out_color_q;
  assign colors_in_use_o  = out_total_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gocl_chk.sv =====
// ----------------------------------------------------------------------------
// gocl_chk: port-level checks for the graph coloring block
// Watches the result stream of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module gocl_chk (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [gocl_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import gocl_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the running count always covers the assigned color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ID_W+COLOR_W+TOTAL_W-1:ID_W+COLOR_W] >
                      {1'b0, m_axis_tdata[ID_W+COLOR_W-1:ID_W]})
    else $error("colors in use below assigned color");

  // padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:ID_W+COLOR_W+TOTAL_W] == '0)
    else $error("result padding not zero");

  // no result right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind greedy_ordered_graph_coloring gocl_chk u_gocl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
